// ===== design/madsr_pkg.sv =====
// shared constants, types and helpers for the multichannel adsr envelope engine
package madsr_pkg;

    localparam int NUM_CHANNELS  = 16;
    localparam int NUM_ENVELOPES = 16;
    localparam int AMP_FRAC_BITS = 16;
    localparam int CH_W   = $clog2(NUM_CHANNELS);
    localparam int ENV_W  = $clog2(NUM_ENVELOPES);
    localparam int AMP_W  = 7 + AMP_FRAC_BITS;
    localparam int DIV_W  = AMP_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam logic [AMP_W-1:0] FULL_AMP = AMP_W'(127) << AMP_FRAC_BITS;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_ON   = 3'd1;
    localparam logic [2:0] OP_OFF  = 3'd2;
    localparam logic [2:0] OP_CTRL = 3'd3;
    localparam logic [2:0] OP_LOAD = 3'd4;

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ATTACK  = 3'd1;
    localparam logic [2:0] PH_DECAY   = 3'd2;
    localparam logic [2:0] PH_SUSTAIN = 3'd3;
    localparam logic [2:0] PH_RELEASE = 3'd4;

    typedef struct packed {
        logic [7:0] atk;
        logic [7:0] dec;
        logic [6:0] sus;
        logic [7:0] rel;
    } env_entry_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

    // floor(p / 127) by reciprocal estimate and one correction, clamped to 127
    function automatic logic [6:0] div127(input logic [13:0] p);
        logic [21:0] est;
        logic [7:0]  q;
        logic [13:0] r;
        est = 22'(p) * 22'd129;
        q   = est[21:14];
        r   = p - 14'(14'(q) * 14'd127);
        if (r >= 14'd127)
            q = q + 8'd1;
        return (q > 8'd127) ? 7'd127 : q[6:0];
    endfunction

endpackage

// ===== design/madsr_divider.sv =====
// shared restoring divider, one quotient bit per cycle
module madsr_divider
    import madsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
                rem_next = trial[DIV_W-1:0];
            else
                rem_next = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
            quo_next = {quo_reg[DIV_W-2:0], ~trial[DIV_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== design/multichannel_adsr_envelope.sv =====
// top level of the sixteen-channel adsr envelope engine
// usage:
// - one command transfer when start is high and busy is low; busy stays high
//   until the last result of that command has been issued
// - results appear on out_channel, action, volume, last for one cycle each,
//   marked by strobe; last flags the final result of a command
// - load, note off with envelope and unused opcodes give no result
// - note on, note off, controller and load pass through the command state; the
//   result, if any, is strobed as busy drops
// - a tick walks the sixteen channels in order: a skipped channel only passes the
//   scan state; a channel with an envelope waits on the shared bit-serial divider
//   for the step size, then applies it, scales the volume unless its release ends,
//   and emits; results trail one channel behind
// - reset clears all channel state and restores the default envelope entries
// - the receiver cannot stall; results are simply issued one per strobe
module multichannel_adsr_envelope
    import madsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] opcode,
    input  logic [3:0] channel,
    input  logic [6:0] velocity,
    input  logic [6:0] channel_volume,
    input  logic       env_valid,
    input  logic [3:0] env_index,
    input  logic [7:0] attack_len,
    input  logic [7:0] decay_len,
    input  logic [6:0] sustain_level,
    input  logic [7:0] release_len,
    output logic       strobe,
    output logic [3:0] out_channel,
    output logic [1:0] action,
    output logic [6:0] volume,
    output logic       last
);

    typedef enum logic [3:0] {
        S_IDLE, S_CMD, S_SCAN, S_STEP_WAIT, S_APPLY, S_VOL_MUL, S_EMIT, S_FLUSH
    } state_t;

    state_t state_reg;

    env_entry_t           env_reg    [NUM_ENVELOPES];
    logic                 active_reg [NUM_CHANNELS];
    logic [2:0]           phase_reg  [NUM_CHANNELS];
    logic [AMP_W-1:0]     amp_reg    [NUM_CHANNELS];
    logic [6:0]           base_reg   [NUM_CHANNELS];
    logic                 evalid_reg [NUM_CHANNELS];
    logic [3:0]           eidx_reg   [NUM_CHANNELS];

    logic [2:0]  op_reg;
    logic [3:0]  ch_reg;
    logic [6:0]  vel_reg, cvol_reg;
    logic        ev_reg;
    logic [3:0]  ei_reg;
    logic [CH_W:0] scan_reg;
    logic [CH_W-1:0] cur_reg;
    logic [AMP_W-1:0] amp_w_reg;
    logic [AMP_W+6:0] prod_reg;
    logic        stop_reg;

    logic        pend_reg;
    logic [3:0]  pch_reg;
    logic [1:0]  pact_reg;
    logic [6:0]  pvol_reg;

    logic        strobe_reg, last_reg;
    logic [3:0]  och_reg;
    logic [1:0]  act_reg;
    logic [6:0]  vol_reg;

    logic             div_go_reg;
    logic [DIV_W-1:0] div_num_reg, div_den_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    env_entry_t       ce;
    logic [AMP_W-1:0] sus_amp, cur_amp;
    logic [2:0]       cphase;
    logic [AMP_W+6:0] prod;
    logic [6:0]       base_on;
    logic [13:0]      vc;
    logic [6:0]       vol_q;
    logic             rel_done;
    logic [AMP_W:0]   sum_att;
    logic [AMP_W:0]   sum_sus;

    logic             chan_ok;
    logic [7:0]       len1_s;
    logic [AMP_W-1:0] span_s;
    logic [CH_W-1:0]  sidx;
    env_entry_t       se;
    logic [AMP_W-1:0] ssus;

    madsr_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        dreq.start = div_go_reg;
        dreq.num   = div_num_reg;
        dreq.den   = div_den_reg;
    end

    always_comb
    begin
        ce       = env_reg[eidx_reg[cur_reg][ENV_W-1:0]];
        sus_amp  = AMP_W'(ce.sus) << AMP_FRAC_BITS;
        cur_amp  = amp_reg[cur_reg];
        cphase   = phase_reg[cur_reg];
        sum_att  = {1'b0, cur_amp} + {1'b0, drsp.quo};
        sum_sus  = {1'b0, sus_amp} + {1'b0, drsp.quo};
        rel_done = (cphase == PH_RELEASE) && (cur_amp <= drsp.quo);
        prod     = (AMP_W+7)'(amp_w_reg) * (AMP_W+7)'(base_reg[cur_reg]);
        vol_q    = div127(prod_reg[AMP_W+6:AMP_FRAC_BITS]);
        vc       = 14'(vel_reg) * 14'(cvol_reg);
        base_on  = div127(vc) >> 1;
    end

    always_comb
    begin
        sidx    = scan_reg[CH_W-1:0];
        chan_ok = active_reg[sidx] && evalid_reg[sidx]
                  && (32'(eidx_reg[sidx]) < NUM_ENVELOPES);
        se      = env_reg[eidx_reg[sidx][ENV_W-1:0]];
        ssus    = AMP_W'(se.sus) << AMP_FRAC_BITS;
        case (phase_reg[sidx])
            PH_ATTACK: begin len1_s = se.atk; span_s = FULL_AMP; end
            PH_DECAY:  begin len1_s = se.dec; span_s = FULL_AMP - ssus; end
            default:   begin len1_s = se.rel; span_s = ssus; end
        endcase
        if (len1_s == 8'd0)
            len1_s = 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
            och_reg     <= '0;
            act_reg     <= ACT_SET;
            vol_reg     <= '0;
            pend_reg    <= 1'b0;
            pch_reg     <= '0;
            pact_reg    <= ACT_SET;
            pvol_reg    <= '0;
            div_go_reg  <= 1'b0;
            div_num_reg <= '0;
            div_den_reg <= '0;
            op_reg      <= OP_TICK;
            ch_reg      <= '0;
            vel_reg     <= '0;
            cvol_reg    <= '0;
            ev_reg      <= 1'b0;
            ei_reg      <= '0;
            scan_reg    <= '0;
            cur_reg     <= '0;
            amp_w_reg   <= '0;
            prod_reg    <= '0;
            stop_reg    <= 1'b0;
            for (int i = 0; i < NUM_ENVELOPES; i++)
                env_reg[i] <= '{atk: 8'd4, dec: 8'd8, sus: 7'd100, rel: 8'd12};
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                active_reg[i] <= 1'b0;
                phase_reg[i]  <= PH_IDLE;
                amp_reg[i]    <= '0;
                base_reg[i]   <= 7'd127;
                evalid_reg[i] <= 1'b0;
                eidx_reg[i]   <= '0;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;
            div_go_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg   <= opcode;
                        ch_reg   <= channel;
                        vel_reg  <= velocity;
                        cvol_reg <= channel_volume;
                        ev_reg   <= env_valid;
                        ei_reg   <= env_index;
                        if (opcode == OP_LOAD && 32'(env_index) < NUM_ENVELOPES)
                            env_reg[env_index[ENV_W-1:0]] <= '{atk: attack_len,
                                dec: decay_len, sus: sustain_level, rel: release_len};
                        state_reg <= (opcode == OP_TICK) ? S_SCAN : S_CMD;
                        scan_reg  <= '0;
                        pend_reg  <= 1'b0;
                    end
                end
                S_CMD:
                begin
                    state_reg <= S_IDLE;
                    if (32'(ch_reg) < NUM_CHANNELS)
                    begin
                        unique case (op_reg)
                            OP_ON:
                            begin
                                base_reg[ch_reg[CH_W-1:0]]   <= base_on;
                                active_reg[ch_reg[CH_W-1:0]] <= 1'b1;
                                evalid_reg[ch_reg[CH_W-1:0]] <= ev_reg;
                                eidx_reg[ch_reg[CH_W-1:0]]   <= ei_reg;
                                if (ev_reg)
                                begin
                                    phase_reg[ch_reg[CH_W-1:0]] <= PH_ATTACK;
                                    amp_reg[ch_reg[CH_W-1:0]]   <= '0;
                                end
                                strobe_reg <= 1'b1;
                                last_reg   <= 1'b1;
                                och_reg    <= ch_reg;
                                act_reg    <= ACT_START;
                                vol_reg    <= base_on;
                            end
                            OP_OFF:
                            begin
                                if (!ev_reg)
                                begin
                                    active_reg[ch_reg[CH_W-1:0]] <= 1'b0;
                                    strobe_reg <= 1'b1;
                                    last_reg   <= 1'b1;
                                    och_reg    <= ch_reg;
                                    act_reg    <= ACT_STOP;
                                    vol_reg    <= '0;
                                end
                                else
                                    phase_reg[ch_reg[CH_W-1:0]] <= PH_RELEASE;
                            end
                            OP_CTRL:
                            begin
                                evalid_reg[ch_reg[CH_W-1:0]] <= ev_reg;
                                eidx_reg[ch_reg[CH_W-1:0]]   <= ei_reg;
                                strobe_reg <= 1'b1;
                                last_reg   <= 1'b1;
                                och_reg    <= ch_reg;
                                act_reg    <= ACT_SET;
                                vol_reg    <= base_reg[ch_reg[CH_W-1:0]];
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg == (CH_W+1)'(NUM_CHANNELS))
                        state_reg <= S_FLUSH;
                    else
                    begin
                        cur_reg  <= sidx;
                        scan_reg <= scan_reg + 1'b1;
                        if (chan_ok)
                        begin
                            state_reg   <= S_STEP_WAIT;
                            div_go_reg  <= 1'b1;
                            div_num_reg <= DIV_W'(span_s) + DIV_W'(len1_s) - DIV_W'(1);
                            div_den_reg <= DIV_W'(len1_s);
                        end
                    end
                end
                S_STEP_WAIT:
                begin
                    if (drsp.done)
                        state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    stop_reg  <= rel_done;
                    amp_w_reg <= cur_amp;
                    unique case (cphase)
                        PH_ATTACK:
                        begin
                            if (sum_att >= {1'b0, FULL_AMP})
                            begin
                                amp_w_reg <= FULL_AMP;
                                phase_reg[cur_reg] <= PH_DECAY;
                            end
                            else
                                amp_w_reg <= sum_att[AMP_W-1:0];
                        end
                        PH_DECAY:
                        begin
                            if ({1'b0, cur_amp} <= sum_sus)
                            begin
                                amp_w_reg <= sus_amp;
                                phase_reg[cur_reg] <= PH_SUSTAIN;
                            end
                            else
                                amp_w_reg <= cur_amp - drsp.quo;
                        end
                        PH_RELEASE:
                        begin
                            if (rel_done)
                            begin
                                amp_reg[cur_reg]    <= '0;
                                phase_reg[cur_reg]  <= PH_IDLE;
                                active_reg[cur_reg] <= 1'b0;
                            end
                            else
                                amp_w_reg <= cur_amp - drsp.quo;
                        end
                        default: ;
                    endcase
                    state_reg <= rel_done ? S_EMIT : S_VOL_MUL;
                end
                S_VOL_MUL:
                begin
                    amp_reg[cur_reg] <= amp_w_reg;
                    prod_reg  <= prod;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (pend_reg)
                    begin
                        strobe_reg <= 1'b1;
                        last_reg   <= 1'b0;
                        och_reg    <= pch_reg;
                        act_reg    <= pact_reg;
                        vol_reg    <= pvol_reg;
                    end
                    pend_reg  <= 1'b1;
                    pch_reg   <= 4'(cur_reg);
                    pact_reg  <= stop_reg ? ACT_STOP : ACT_SET;
                    pvol_reg  <= stop_reg ? 7'd0 : vol_q;
                    state_reg <= S_SCAN;
                end
                S_FLUSH:
                begin
                    if (pend_reg)
                    begin
                        strobe_reg <= 1'b1;
                        last_reg   <= 1'b1;
                        och_reg    <= pch_reg;
                        act_reg    <= pact_reg;
                        vol_reg    <= pvol_reg;
                    end
                    pend_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign out_channel = och_reg;
    assign action      = act_reg;
    assign volume      = vol_reg;
    assign last        = last_reg;

endmodule

// ===== design/madsr_checker.sv =====
// port-level checks for the envelope engine, bound to the top level
module madsr_checker
    import madsr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [1:0] action,
    input logic [6:0] volume
);

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && action == ACT_STOP |-> volume == 7'd0)
        else $error("stop with nonzero volume");

    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> action != 2'd3)
        else $error("bad action code");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after transfer");

    a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !strobe)
        else $error("result while idle");

endmodule

bind multichannel_adsr_envelope madsr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .strobe(strobe), .action(action), .volume(volume)
);

// ===== verif/tb_top.sv =====
// self-checking testbench for the multichannel adsr envelope engine
`timescale 1ns / 100ps

module tb_top;
    import madsr_pkg::*;

    typedef struct packed {
        logic [3:0] chn;
        logic [1:0] act;
        logic [6:0] vol;
        logic       fin;
    } env_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] opcode = OP_TICK;
    logic [3:0] channel = '0;
    logic [6:0] velocity = '0;
    logic [6:0] channel_volume = '0;
    logic       env_valid = 1'b0;
    logic [3:0] env_index = '0;
    logic [7:0] attack_len = '0;
    logic [7:0] decay_len = '0;
    logic [6:0] sustain_level = '0;
    logic [7:0] release_len = '0;
    logic       strobe;
    logic [3:0] out_channel;
    logic [1:0] action;
    logic [6:0] volume;
    logic       last;

    env_entry_t  env_tab [NUM_ENVELOPES];
    logic        v_on [NUM_CHANNELS];
    logic [2:0]  v_phase [NUM_CHANNELS];
    logic [63:0] v_amp [NUM_CHANNELS];
    logic [6:0]  v_base [NUM_CHANNELS];
    logic        v_sel_ok [NUM_CHANNELS];
    logic [3:0]  v_sel [NUM_CHANNELS];

    env_result_t pending_results[$];
    int errors = 0;
    int idle_cycles = 0;
    localparam int WATCHDOG = 20000;

    always #4 clk = ~clk;

    multichannel_adsr_envelope DUT (.*);

    function automatic logic [63:0] len_or_one(logic [7:0] v);
        return (v == 0) ? 64'd1 : 64'(v);
    endfunction

    function automatic logic [63:0] div_up(logic [63:0] n, logic [63:0] d);
        return (n + d - 1) / d;
    endfunction

    task automatic model_reset();
        for (int i = 0; i < NUM_ENVELOPES; i++)
            env_tab[i] = '{atk: 8'd4, dec: 8'd8, sus: 7'd100, rel: 8'd12};
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            v_on[i] = 0; v_phase[i] = PH_IDLE; v_amp[i] = 0;
            v_base[i] = 7'd127; v_sel_ok[i] = 0; v_sel[i] = 0;
        end
    endtask

    task automatic push_result(int ch, logic [1:0] a, int v);
        env_result_t r;
        r.chn = ch[3:0]; r.act = a; r.vol = v[6:0]; r.fin = 1'b0;
        pending_results = {pending_results, r};
    endtask

    task automatic predict_tick();
        logic [63:0] full, amp, sus, stp, vol;
        env_entry_t e;
        full = 64'(FULL_AMP);
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            if (!v_on[ch] || !v_sel_ok[ch]) continue;
            e = env_tab[v_sel[ch]];
            amp = v_amp[ch];
            sus = 64'(e.sus) << AMP_FRAC_BITS;
            if (v_phase[ch] == PH_ATTACK)
            begin
                amp += div_up(full, len_or_one(e.atk));
                if (amp >= full)
                begin
                    amp = full; v_phase[ch] = PH_DECAY;
                end
            end
            else if (v_phase[ch] == PH_DECAY)
            begin
                stp = div_up(full - sus, len_or_one(e.dec));
                if (amp <= sus + stp)
                begin
                    amp = sus; v_phase[ch] = PH_SUSTAIN;
                end
                else amp -= stp;
            end
            else if (v_phase[ch] == PH_RELEASE)
            begin
                stp = div_up(sus, len_or_one(e.rel));
                if (amp <= stp)
                begin
                    v_amp[ch] = 0; v_phase[ch] = PH_IDLE; v_on[ch] = 0;
                    push_result(ch, ACT_STOP, 0);
                    continue;
                end
                amp -= stp;
            end
            if (amp > full) amp = full;
            v_amp[ch] = amp;
            vol = (amp * v_base[ch]) / full;
            if (vol > 127) vol = 127;
            push_result(ch, ACT_SET, int'(vol));
        end
    endtask

    task automatic predict_command(logic [2:0] op, int ch, int vel, int cv, logic ev, int ei,
                                   int a, int d, int s, int r);
        int prev_count, fv;
        prev_count = pending_results.size();
        if (op == OP_TICK) predict_tick();
        else if (op == OP_LOAD)
            env_tab[ei] = '{atk: a[7:0], dec: d[7:0], sus: s[6:0], rel: r[7:0]};
        else if (op == OP_ON)
        begin
            fv = ((int'(vel[6:0]) * int'(cv[6:0])) / 127) / 2;
            v_base[ch] = fv[6:0]; v_on[ch] = 1; v_sel_ok[ch] = ev; v_sel[ch] = ei[3:0];
            if (ev)
            begin
                v_phase[ch] = PH_ATTACK; v_amp[ch] = 0;
            end
            push_result(ch, ACT_START, fv);
        end
        else if (op == OP_OFF)
        begin
            if (!ev)
            begin
                v_on[ch] = 0; push_result(ch, ACT_STOP, 0);
            end
            else v_phase[ch] = PH_RELEASE;
        end
        else if (op == OP_CTRL)
        begin
            v_sel_ok[ch] = ev; v_sel[ch] = ei[3:0];
            push_result(ch, ACT_SET, v_base[ch]);
        end
        if (pending_results.size() > prev_count)
            pending_results[pending_results.size() - 1].fin = 1'b1;
    endtask

    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 40) n = 0;
        else if (n < 92) n = $urandom_range(1, 4);
        else n = $urandom_range(10, 60);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_command(logic [2:0] op, int ch, int vel, int cv, logic ev, int ei,
                                int a = 0, int d = 0, int s = 0, int r = 0);
        random_gap();
        opcode <= op; channel <= ch[3:0]; velocity <= vel[6:0];
        channel_volume <= cv[6:0]; env_valid <= ev; env_index <= ei[3:0];
        attack_len <= a[7:0]; decay_len <= d[7:0]; sustain_level <= s[6:0];
        release_len <= r[7:0]; start <= 1'b1;
        do @(posedge clk); while (busy);
        predict_command(op, ch, vel, cv, ev, ei, a, d, s, r);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result ch %0d act %0d vol %0d",
                                           out_channel, action, volume);
            end
            else
            begin
                env_result_t e;
                e = pending_results.pop_front();
                if (e.chn !== out_channel || e.act !== action || e.vol !== volume ||
                    e.fin !== last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp ch %0d act %0d vol %0d last %0d,",
                                  " got %0d %0d %0d %0d"},
                                 e.chn, e.act, e.vol, e.fin, out_channel, action, volume, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (strobe || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("** multichannel_adsr_envelope: FAILED **");
            $finish;
        end
    end

    task automatic test_directed();
        send_command(OP_TICK, 0, 0, 0, 0, 0);
        send_command(OP_ON, 0, 127, 127, 1, 0);
        send_command(OP_ON, 15, 0, 0, 1, 15);
        send_command(OP_ON, 5, 127, 1, 0, 3);
        send_command(OP_LOAD, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        send_command(OP_LOAD, 0, 0, 0, 0, 15, 255, 255, 127, 255);
        send_command(OP_ON, 1, 100, 90, 1, 1);
        send_command(OP_CTRL, 3, 0, 0, 1, 2);
        repeat (3) send_command(OP_TICK, 0, 0, 0, 0, 0);
        send_command(OP_OFF, 0, 0, 0, 1, 0);
        send_command(OP_OFF, 1, 0, 0, 1, 0);
        send_command(OP_OFF, 5, 0, 0, 0, 0);
        send_command(3'd5, 0, 0, 0, 0, 0);
        send_command(3'd7, 0, 0, 0, 0, 0);
        send_command(3'd6, 15, 127, 127, 1, 15);
        repeat (4) send_command(OP_TICK, 0, 0, 0, 0, 0);
        send_command(OP_CTRL, 15, 0, 0, 0, 15);
    endtask

    task automatic test_random();
        int k, sel;
        for (k = 0; k < 360; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40) send_command(OP_TICK, $urandom, $urandom, $urandom, $urandom, 0);
            else if (sel < 58)
                send_command(OP_ON, $urandom_range(0, 15), $urandom, $urandom,
                             ($urandom_range(0, 9) != 0), $urandom_range(0, 15));
            else if (sel < 72)
                send_command(OP_OFF, $urandom_range(0, 15), $urandom, $urandom,
                             ($urandom_range(0, 4) != 0), $urandom_range(0, 15));
            else if (sel < 80)
                send_command(OP_CTRL, $urandom_range(0, 15), $urandom, $urandom,
                             $urandom, $urandom_range(0, 15));
            else if (sel < 96)
                send_command(OP_LOAD, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(0, 15), $urandom_range(0, 12),
                             ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12),
                             $urandom, $urandom_range(0, 20));
            else
                send_command(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                             $urandom, $urandom);
        end
    endtask

    initial
    begin
        model_reset();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (1000) @(negedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("** multichannel_adsr_envelope: PASSED **");
        else
            $display("** multichannel_adsr_envelope: FAILED **");
        $finish;
    end

endmodule

// ===== multichannel_adsr_envelope.f =====
design/madsr_pkg.sv
design/madsr_divider.sv
design/multichannel_adsr_envelope.sv
design/madsr_checker.sv
verif/tb_top.sv
